/* rtl/core/u8d_pkg.sv */
package u8d_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [20:0] CP_REPL = 21'h00FFFD;

  // Byte classes as seen by the front end.
  typedef enum logic [2:0] {
    CL_ASCII,
    CL_CONT,
    CL_LEAD2,
    CL_LEAD3,
    CL_LEAD4,
    CL_BAD
  } byte_class_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  byte_value;
    byte_class_t cls;
  } item_t;

  function automatic byte_class_t classify(logic [7:0] b);
    byte_class_t r;
    if (!b[7])                r = CL_ASCII;
    else if (!b[6])           r = CL_CONT;
    else if (!b[5])           r = CL_LEAD2;
    else if (!b[4])           r = CL_LEAD3;
    else if (!b[3])           r = CL_LEAD4;
    else                      r = CL_BAD;
    return r;
  endfunction

endpackage

/* rtl/core/utf8_stream_decoder.sv */
// UTF-8 stream decoder.
// Input channel (in_valid/in_ready): one word per transfer, either a data
// byte (in_mode = 0, in_byte_value) or an end-of-stream mark (in_mode = 1).
// Output channel (out_valid/out_ready): one decoded code point per word,
// U+FFFD for any malformed or rejected input. A word yields zero or one
// code point; lead and middle bytes of a sequence yield none.
// A word accepted by the front end waits in the front queue; when the back
// end pops it, it registers the code point (if any) onto out_code_point.
// Throughput: one word per cycle, sustained. The back end updates its phase
// as it pops each word, so nothing limits the rate but the output
// handshake.
// Reset (rst_n low, synchronous) empties the queue, drops any pending
// output and returns the decoder to the start phase.
// When the receiver stalls, the output register holds its word, the back
// end stops popping, and the two-entry queue fills; in_ready drops once the
// queue is full and rises as soon as an entry drains.
module utf8_stream_decoder
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [7:0]  in_byte_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_code_point
);

  // front end to queue
  logic  q_push;
  logic  q_full;
  item_t q_wr_item;

  // queue to back end
  logic  q_pop;
  logic  q_not_empty;
  item_t q_rd_item;

  // Classify each incoming word and push it.
  u8d_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_byte_value (in_byte_value),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_wr_item)
  );

  // Decouple the two sides so each can stall on its own.
  u8d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_wr_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_rd_item),
    .not_empty (q_not_empty)
  );

  // Advance the phase machine and register the result word.
  u8d_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_not_empty),
    .q_item         (q_rd_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point)
  );

endmodule

/* rtl/core/u8d_front.sv */
module u8d_front
  import u8d_pkg::*;
(
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_mode,
  input  logic [7:0] in_byte_value,
  input  logic       q_full,
  output logic       q_push,
  output item_t      q_item
);

  // Accept whenever the queue has room; tag each word with its byte class.
  assign in_ready          = !q_full;
  assign q_push            = in_valid && !q_full;
  assign q_item.mode       = in_mode;
  assign q_item.byte_value = in_byte_value;
  assign q_item.cls        = classify(in_byte_value);

endmodule

/* rtl/core/u8d_queue.sv */
module u8d_queue
  import u8d_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t pop_item,
  output logic  not_empty
);

  item_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r;
  logic [QUEUE_AW-1:0]  rd_ptr_r;
  logic [QUEUE_AW:0]    count_r;
  logic [QUEUE_AW-1:0]  wr_ptr_nxt;
  logic [QUEUE_AW-1:0]  rd_ptr_nxt;
  logic [QUEUE_AW:0]    count_nxt;

  localparam logic [QUEUE_AW:0]   CountFull = (QUEUE_AW+1)'(QUEUE_DEPTH);
  localparam logic [QUEUE_AW-1:0] PtrLast   = QUEUE_AW'(QUEUE_DEPTH - 1);

  assign full      = (count_r == CountFull);
  assign not_empty = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* rtl/core/u8d_back.sv */
module u8d_back
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_code_point
);

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_S22   = 3'd1;
  localparam logic [2:0] PH_S23   = 3'd2;
  localparam logic [2:0] PH_S24   = 3'd3;
  localparam logic [2:0] PH_S33   = 3'd4;
  localparam logic [2:0] PH_S34   = 3'd5;
  localparam logic [2:0] PH_RECOV = 3'd6;
  localparam logic [2:0] PH_S44   = 3'd7;

  function automatic logic [20:0] check2(logic [10:0] v);
    return (v < 11'h080) ? CP_REPL : {10'b0, v};
  endfunction

  function automatic logic [20:0] check3(logic [15:0] v);
    logic bad;
    bad = (v < 16'h0800) || (v[15:11] == 5'b11011) || (v[15:1] == 15'h7FFF);
    return bad ? CP_REPL : {5'b0, v};
  endfunction

  function automatic logic [20:0] check4(logic [20:0] v);
    logic bad;
    bad = (v < 21'h010000) || (v > 21'h10FFFD) || (v[15:1] == 15'h7FFF);
    return bad ? CP_REPL : v;
  endfunction

  logic [2:0]  phase_r, phase_nxt;
  logic [14:0] pbits_r, pbits_nxt;
  logic        out_valid_r;
  logic [20:0] out_cp_r;
  logic        emit;
  logic [20:0] cp;
  logic [7:0]  b;
  logic [5:0]  c;
  byte_class_t hcls;

  assign b       = q_item.byte_value;
  assign c       = b[5:0];
  assign hcls    = classify(pbits_r[7:0]);
  assign q_pop   = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    emit      = 1'b0;
    cp        = CP_REPL;
    phase_nxt = phase_r;
    pbits_nxt = pbits_r;
    if (q_item.mode) begin
      // end of stream: flush whatever is pending
      emit      = (phase_r != PH_START);
      if (phase_r == PH_RECOV && !pbits_r[7]) begin
        cp = {14'b0, pbits_r[6:0]};
      end
      phase_nxt = PH_START;
      pbits_nxt = '0;
    end else begin
      case (phase_r)
        PH_START: begin
          case (q_item.cls)
            CL_ASCII: begin
              emit = 1'b1;
              cp   = {13'b0, b};
            end
            CL_LEAD2: begin
              phase_nxt = PH_S22;
              pbits_nxt = {10'b0, b[4:0]};
            end
            CL_LEAD3: begin
              phase_nxt = PH_S23;
              pbits_nxt = {11'b0, b[3:0]};
            end
            CL_LEAD4: begin
              phase_nxt = PH_S24;
              pbits_nxt = {12'b0, b[2:0]};
            end
            default: begin
              emit      = 1'b1;
              phase_nxt = PH_START;
              pbits_nxt = '0;
            end
          endcase
        end
        PH_RECOV: begin
          if (hcls == CL_ASCII) begin
            emit      = 1'b1;
            cp        = {13'b0, pbits_r[7:0]};
            pbits_nxt = {7'b0, b};
          end else if (hcls == CL_CONT || hcls == CL_BAD || q_item.cls != CL_CONT) begin
            emit      = 1'b1;
            pbits_nxt = {7'b0, b};
          end else if (hcls == CL_LEAD2) begin
            emit      = 1'b1;
            cp        = check2({pbits_r[4:0], c});
            phase_nxt = PH_START;
            pbits_nxt = '0;
          end else if (hcls == CL_LEAD3) begin
            phase_nxt = PH_S33;
            pbits_nxt = {5'b0, pbits_r[3:0], c};
          end else begin
            phase_nxt = PH_S34;
            pbits_nxt = {6'b0, pbits_r[2:0], c};
          end
        end
        default: begin
          if (q_item.cls != CL_CONT) begin
            // broken sequence: hold the offending byte
            emit      = 1'b1;
            phase_nxt = PH_RECOV;
            pbits_nxt = {7'b0, b};
          end else begin
            case (phase_r)
              PH_S22: begin
                emit      = 1'b1;
                cp        = check2({pbits_r[4:0], c});
                phase_nxt = PH_START;
                pbits_nxt = '0;
              end
              PH_S23: begin
                phase_nxt = PH_S33;
                pbits_nxt = {5'b0, pbits_r[3:0], c};
              end
              PH_S24: begin
                phase_nxt = PH_S34;
                pbits_nxt = {6'b0, pbits_r[2:0], c};
              end
              PH_S34: begin
                phase_nxt = PH_S44;
                pbits_nxt = {pbits_r[8:0], c};
              end
              PH_S33: begin
                emit      = 1'b1;
                cp        = check3({pbits_r[9:0], c});
                phase_nxt = PH_START;
                pbits_nxt = '0;
              end
              default: begin
                emit      = 1'b1;
                cp        = check4({pbits_r, c});
                phase_nxt = PH_START;
                pbits_nxt = '0;
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      pbits_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r     <= phase_nxt;
        pbits_r     <= pbits_nxt;
        out_valid_r <= emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_cp_r <= cp;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = out_cp_r;

endmodule

/* rtl/core/u8d_checker.sv */
module u8d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [20:0] out_code_point
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_point))
    else $error("result word changed while stalled");

  // Reset drops any pending result.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_code_point <= 21'h10FFFD)
    else $error("code point out of range");

  a_no_surrogate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_code_point[20:11] != 10'b0000011011)
    else $error("surrogate emitted");

  a_no_nonchar: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_code_point[15:1] != 15'h7FFF)
    else $error("non-character emitted");

endmodule

bind utf8_stream_decoder u8d_checker u_u8d_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_code_point (out_code_point)
);
